// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");

// check a consequence in the cycle after its antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/pdpcs_pkg.sv =====
// ----------------------------------------------------------------------------
// pdpcs_pkg
// Types and constants of the PDP context session state machine.
// ----------------------------------------------------------------------------
`default_nettype none

package pdpcs_pkg;

    localparam int TIMER_W   = 16;
    localparam int ATTEMPT_W = 3;
    localparam int CAUSE_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    localparam logic [TIMER_W-1:0]   RETRY_TIMEOUT_RST = 16'd1000;
    localparam logic [ATTEMPT_W-1:0] MAX_ATTEMPTS_RST  = 3'd4;
    localparam logic [CAUSE_W-1:0]   TIMEOUT_CAUSE_RST = 8'd34;
    localparam logic [ATTEMPT_W-1:0] ATTEMPT_SAT       = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_CAUSE = 2'd2;

    typedef enum logic [2:0] {
        ST_INACTIVE   = 3'd0,
        ST_ACT_PEND   = 3'd1,
        ST_ACTIVE     = 3'd2,
        ST_MOD_PEND   = 3'd3,
        ST_INACT_PEND = 3'd4
    } t_state;

    typedef enum logic [2:0] {
        ACT_NONE     = 3'd0,
        ACT_ASSIGN   = 3'd1,
        ACT_SEND_ACT = 3'd2,
        ACT_CONFIRM  = 3'd3,
        ACT_IND      = 3'd4,
        ACT_RELEASE  = 3'd5
    } t_action;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_GMM_EST_CNF  = 4'd1,
        OP_GMM_EST_REJ  = 4'd2,
        OP_TX_ACT_REQ   = 4'd3,
        OP_RX_ACT_REJ   = 4'd4,
        OP_RX_ACT_ACC   = 4'd5,
        OP_NSAPI_ACTIVE = 4'd6,
        OP_TX_DEACT_REQ = 4'd7,
        OP_RX_DEACT_REQ = 4'd8,
        OP_RX_DEACT_ACC = 4'd9,
        OP_TX_MOD_REQ   = 4'd10,
        OP_RX_MOD_REJ   = 4'd11,
        OP_RX_MOD_ACC   = 4'd12
    } t_op;

endpackage

`default_nettype wire

// ===== rtl/core/pdp_context_session_fsm.sv =====
// ----------------------------------------------------------------------------
// pdp_context_session_fsm
// Mobile-side PDP context session state machine with retry timer and release.
// ----------------------------------------------------------------------------
// Takes one event word per cycle while the result register is free or being
// taken, and returns one result word for each, in order. The state update and
// the result are computed in the cycle the event word is accepted and land in
// the output register at that edge, so the block sustains one word per clock
// while the consumer keeps up; a waiting result does not stall input as long as
// the consumer takes it in the same cycle. Configuration writes are taken at any
// time but are meant for idle periods.
`default_nettype none

`include "assert_macros.svh"

module pdp_context_session_fsm
    import pdpcs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    // event stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [15:0]          s_axis_tdata,  // op[3:0], reject_cause[11:4], zero
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata   // action[2:0], confirm_cause[10:3],
                                                     // session_state[13:11], event_error[14],
                                                     // zero
);

    logic [TIMER_W-1:0]   r_retry_timeout;
    logic [ATTEMPT_W-1:0] r_max_attempts;
    logic [CAUSE_W-1:0]   r_timeout_cause;

    t_state               r_state, n_state;
    logic [TIMER_W-1:0]   r_timer, n_timer;
    logic                 r_timer_running, n_timer_running;
    logic [ATTEMPT_W-1:0] r_attempt, n_attempt;
    logic                 r_release, n_release;

    logic                 r_out_valid;
    t_action              r_out_action;
    logic [CAUSE_W-1:0]   r_out_cause;
    t_state               r_out_state;
    logic                 r_out_error;

    t_action              w_action;
    logic [CAUSE_W-1:0]   w_cause;
    logic                 w_error;

    logic                 w_in_acc;
    t_op                  w_op;
    logic [CAUSE_W-1:0]   w_rej_cause;
    logic [TIMER_W-1:0]   w_timer_dec;
    logic                 w_expire;
    logic [ATTEMPT_W-1:0] w_attempt_inc;
    logic                 w_abort;
    logic [TIMER_W-1:0]   w_timer_load;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_op          = t_op'(s_axis_tdata[3:0]);
    assign w_rej_cause   = s_axis_tdata[11:4];

    assign w_timer_dec   = r_timer - TIMER_W'(1);
    assign w_expire      = r_timer_running && (w_timer_dec == '0);
    assign w_attempt_inc = (r_attempt == ATTEMPT_SAT) ? r_attempt : r_attempt + ATTEMPT_W'(1);
    assign w_abort       = w_attempt_inc >= r_max_attempts;
    assign w_timer_load  = (r_retry_timeout == '0) ? TIMER_W'(1) : r_retry_timeout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_retry_timeout <= RETRY_TIMEOUT_RST;
            r_max_attempts  <= MAX_ATTEMPTS_RST;
            r_timeout_cause <= TIMEOUT_CAUSE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RETRY_TIMEOUT: r_retry_timeout <= i_cfg_data[TIMER_W-1:0];
                CFG_MAX_ATTEMPTS:  r_max_attempts  <= i_cfg_data[ATTEMPT_W-1:0];
                CFG_TIMEOUT_CAUSE: r_timeout_cause <= i_cfg_data[CAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state         = r_state;
        n_timer         = r_timer;
        n_timer_running = r_timer_running;
        n_attempt       = r_attempt;
        n_release       = r_release;
        if (w_in_acc) begin
            case (r_state)
                ST_INACTIVE: begin
                    if (w_op == OP_TICK && r_release) begin
                        n_release = 1'b0;
                        n_attempt = '0;
                    end else if (w_op == OP_TX_ACT_REQ) begin
                        n_attempt       = '0;
                        n_state         = ST_ACT_PEND;
                        n_timer         = w_timer_load;
                        n_timer_running = 1'b1;
                        n_release       = 1'b0;
                    end
                end
                ST_ACT_PEND: begin
                    case (w_op)
                        OP_TICK: begin
                            if (r_timer_running) begin
                                n_timer = w_timer_dec;
                                if (w_expire) begin
                                    n_attempt = w_attempt_inc;
                                    if (w_abort) begin
                                        n_state         = ST_INACTIVE;
                                        n_timer         = '0;
                                        n_timer_running = 1'b0;
                                        n_release       = 1'b1;
                                    end else begin
                                        n_timer         = w_timer_load;
                                        n_timer_running = 1'b1;
                                        n_release       = 1'b0;
                                    end
                                end
                            end
                        end
                        OP_GMM_EST_REJ, OP_RX_ACT_REJ: begin
                            n_state         = ST_INACTIVE;
                            n_timer         = '0;
                            n_timer_running = 1'b0;
                            n_release       = 1'b1;
                        end
                        OP_NSAPI_ACTIVE: begin
                            n_state         = ST_ACTIVE;
                            n_timer         = '0;
                            n_timer_running = 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_ACTIVE: begin
                    case (w_op)
                        OP_TX_DEACT_REQ: n_state = ST_INACT_PEND;
                        OP_TX_MOD_REQ:   n_state = ST_MOD_PEND;
                        OP_RX_DEACT_REQ: begin
                            n_state         = ST_INACTIVE;
                            n_timer         = '0;
                            n_timer_running = 1'b0;
                            n_release       = 1'b1;
                        end
                        default: ;
                    endcase
                end
                ST_MOD_PEND: begin
                    case (w_op)
                        OP_RX_MOD_REJ: n_state = ST_INACT_PEND;
                        OP_RX_MOD_ACC: n_state = ST_ACTIVE;
                        OP_RX_DEACT_REQ: begin
                            n_state         = ST_INACTIVE;
                            n_timer         = '0;
                            n_timer_running = 1'b0;
                            n_release       = 1'b1;
                        end
                        default: ;
                    endcase
                end
                ST_INACT_PEND: begin
                    if (w_op == OP_RX_DEACT_ACC) begin
                        n_state         = ST_INACTIVE;
                        n_timer         = '0;
                        n_timer_running = 1'b0;
                        n_release       = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // result
    always_comb begin
        w_action = ACT_NONE;
        w_cause  = '0;
        w_error  = 1'b0;
        if (w_op == OP_TICK) begin
            if (r_state == ST_INACTIVE && r_release) begin
                w_action = ACT_RELEASE;
            end else if (r_state == ST_ACT_PEND && w_expire) begin
                if (w_abort) begin
                    w_action = ACT_CONFIRM;
                    w_cause  = r_timeout_cause;
                end else begin
                    w_action = ACT_ASSIGN;
                end
            end
        end else begin
            w_error = 1'b1;
            case (r_state)
                ST_INACTIVE: begin
                    if (w_op == OP_TX_ACT_REQ) begin
                        w_action = ACT_ASSIGN;
                        w_error  = 1'b0;
                    end
                end
                ST_ACT_PEND: begin
                    case (w_op)
                        OP_GMM_EST_CNF: begin
                            w_action = ACT_SEND_ACT;
                            w_error  = 1'b0;
                        end
                        OP_GMM_EST_REJ: w_error = 1'b0;
                        OP_RX_ACT_REJ: begin
                            w_action = ACT_CONFIRM;
                            w_cause  = w_rej_cause;
                            w_error  = 1'b0;
                        end
                        OP_RX_ACT_ACC: begin
                            w_action = ACT_IND;
                            w_error  = 1'b0;
                        end
                        OP_NSAPI_ACTIVE: begin
                            w_action = ACT_CONFIRM;
                            w_error  = 1'b0;
                        end
                        default: ;
                    endcase
                end
                ST_ACTIVE: begin
                    if (w_op == OP_TX_DEACT_REQ || w_op == OP_RX_DEACT_REQ
                            || w_op == OP_TX_MOD_REQ) begin
                        w_error = 1'b0;
                    end
                end
                ST_MOD_PEND: begin
                    if (w_op == OP_RX_DEACT_REQ || w_op == OP_RX_MOD_REJ
                            || w_op == OP_RX_MOD_ACC) begin
                        w_error = 1'b0;
                    end
                end
                ST_INACT_PEND: begin
                    if (w_op == OP_RX_DEACT_ACC) begin
                        w_error = 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_INACTIVE;
            r_timer         <= '0;
            r_timer_running <= 1'b0;
            r_attempt       <= '0;
            r_release       <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_timer         <= n_timer;
            r_timer_running <= n_timer_running;
            r_attempt       <= n_attempt;
            r_release       <= n_release;
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // hold the result word until taken
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_action <= w_action;
            r_out_cause  <= w_cause;
            r_out_state  <= n_state;
            r_out_error  <= w_error;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_error, r_out_state, r_out_cause, r_out_action};

    `ASSERT_ALWAYS(a_timer_in_act_pend, i_clk, i_rst_n,
        r_timer_running == (r_state == ST_ACT_PEND))
    `ASSERT_ALWAYS(a_timer_nonzero, i_clk, i_rst_n,
        !r_timer_running || (r_timer != '0))
    `ASSERT_ALWAYS(a_release_in_inactive, i_clk, i_rst_n,
        !r_release || (r_state == ST_INACTIVE))
    `ASSERT_NEXT(a_tick_no_error, i_clk, i_rst_n,
        w_in_acc && (w_op == OP_TICK), !r_out_error && r_out_valid)

endmodule

`default_nettype wire
